FILE: rtl/rcba_pkg.sv
// ----------------------------------------------------------------------------
// rcba_pkg: shared types and constants for the refcounted block allocator
// Status codes, controller states and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rcba_pkg;

	localparam int NUM_BLOCKS_DEF  = 1024;
	localparam int MAX_RUN_DEF     = 64;
	localparam int MAX_ALLOC_DEF   = 64;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int EPOCH_W = 8;

	typedef enum logic [1:0] {
		K_ALLOC   = 2'd0,
		K_RETAIN  = 2'd1,
		K_RELEASE = 2'd2,
		K_QUERY   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADID    = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_BADQUERY = 3'd4,
		ST_TOOLONG  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OS_EMPTY,
		OS_OK0,
		OS_ALLOC,
		OS_QBAD,
		OS_QOK,
		OS_RUN
	} out_sel_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_OUT1,
		S_Q_OUT,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_E_START,
		S_WRAP,
		S_E_CHK,
		S_E_MARK,
		S_E_END,
		S_C_BUF,
		S_C_CNT,
		S_C_CHK,
		S_A_BUF,
		S_A_CNT,
		S_A_UPD,
		S_RES
	} state_t;

	typedef struct packed {
		logic     cap;
		logic     sweep_init;
		logic     sweep_seen;
		logic     epoch_inc;
		logic     epoch_one;
		logic     err_long;
		logic     err_bad;
		logic     err_ovf;
		logic     elem_rd;
		logic     elem_mark;
		logic     loop_clr;
		logic     loop_inc;
		logic     buf_rd;
		logic     cnt_rd_buf;
		logic     apply;
		logic     alloc_rd;
		logic     alloc_wr;
		logic     q_rd;
		logic     run_clr;
		logic     emit;
		out_sel_t sel;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  last;
		logic  sweep_last;
		logic  run_len_zero;
		logic  run_err_zero;
		logic  run_full;
		logic  id_oob;
		logic  elem_bad;
		logic  epoch_max;
		logic  loop_done;
		logic  alloc_fail;
		logic  alloc_zero;
		logic  alloc_last;
		logic  cnt_max;
		logic  out_free;
	} stat_t;

endpackage

FILE: rtl/refcounted_block_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_block_allocator: reference-counted fixed block pool
// Input channel (in_valid/in_ready) takes one item: allocate, retain or
// release run element, or count query. Output channel (out_valid/out_ready)
// returns result beats; last_res marks the final beat of an item.
// One item is handled at a time; in_ready is high only when idle.
// Allocate pops one block per result beat from the free stack.
// Query reads one count. A run element is checked and marked; the final
// element adds a commit walk over the buffered ids: one update pass for
// release, a count check pass then an update pass for retain. Every 255
// runs the mark memory is swept. After reset a clearing pass fills the
// stack and zeroes counts and marks; in_ready stays low meanwhile.
// A stalled receiver holds the beat in the result register; the block
// waits only when it must load a new beat while one is still held.
// ----------------------------------------------------------------------------
module refcounted_block_allocator #(
	parameter int NUM_BLOCKS  = rcba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_RUN     = rcba_pkg::MAX_RUN_DEF,
	parameter int MAX_ALLOC   = rcba_pkg::MAX_ALLOC_DEF,
	parameter int COUNT_WIDTH = rcba_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] block_id,
	input  logic [6:0]  alloc_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] block_id_res,
	output logic        id_valid,
	output logic [15:0] ref_count,
	output logic        last_res
);
	import rcba_pkg::*;

	cmd_t  cmd;
	stat_t st;

	rcba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rcba_dp #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.MAX_RUN     (MAX_RUN),
		.MAX_ALLOC   (MAX_ALLOC),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.block_id     (block_id),
		.alloc_count  (alloc_count),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.block_id_res (block_id_res),
		.id_valid     (id_valid),
		.ref_count    (ref_count),
		.last_res     (last_res)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item back to back");

	a_alloc_beat_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && id_valid |-> status == ST_OK && ref_count == 16'd0)
		else $error("allocated id with bad status or count");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last_res && !id_valid && ref_count == 16'd0)
		else $error("error beat not a single final beat");

endmodule

FILE: rtl/rcba_ctrl.sv
// ----------------------------------------------------------------------------
// rcba_ctrl: allocator controller
// Sequences reset and mark sweeps, allocate, query, run element and commit.
// ----------------------------------------------------------------------------
module rcba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcba_pkg::stat_t st,
	output rcba_pkg::cmd_t  cmd
);
	import rcba_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:     if (st.sweep_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (st.kind)
					K_ALLOC: state_d = (st.alloc_fail || st.alloc_zero) ? S_OUT1 : S_ALLOC_RD;
					K_QUERY: state_d = st.id_oob ? S_OUT1 : S_Q_OUT;
					default: state_d = S_E_START;
				endcase
			end
			S_OUT1:     if (st.out_free) state_d = S_IDLE;
			S_Q_OUT:    if (st.out_free) state_d = S_IDLE;
			S_ALLOC_RD: state_d = S_ALLOC_WR;
			S_ALLOC_WR: if (st.out_free) state_d = st.alloc_last ? S_IDLE : S_ALLOC_RD;
			S_E_START: begin
				if (st.run_len_zero && st.run_err_zero && st.epoch_max) state_d = S_WRAP;
				else state_d = S_E_CHK;
			end
			S_WRAP:     if (st.sweep_last) state_d = S_E_CHK;
			S_E_CHK: begin
				if (!st.run_err_zero || st.run_full || st.id_oob) state_d = S_E_END;
				else state_d = S_E_MARK;
			end
			S_E_MARK:   state_d = S_E_END;
			S_E_END: begin
				if (!st.last) state_d = S_IDLE;
				else if (!st.run_err_zero) state_d = S_RES;
				else if (st.kind == K_RETAIN) state_d = S_C_BUF;
				else state_d = S_A_BUF;
			end
			S_C_BUF:    state_d = st.loop_done ? S_A_BUF : S_C_CNT;
			S_C_CNT:    state_d = S_C_CHK;
			S_C_CHK:    state_d = st.cnt_max ? S_RES : S_C_BUF;
			S_A_BUF:    state_d = st.loop_done ? S_RES : S_A_CNT;
			S_A_CNT:    state_d = S_A_UPD;
			S_A_UPD:    state_d = S_A_BUF;
			S_RES:      if (st.out_free) state_d = S_IDLE;
			default:    state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = OS_RUN;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: cmd.sweep_init = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.cap = in_valid;
			end
			S_DISPATCH: begin
				cmd.loop_clr = 1'b1;
				if (st.kind == K_QUERY && !st.id_oob) cmd.q_rd = 1'b1;
			end
			S_OUT1: begin
				cmd.emit = st.out_free;
				if (st.kind == K_QUERY) cmd.sel = OS_QBAD;
				else if (st.alloc_fail) cmd.sel = OS_EMPTY;
				else cmd.sel = OS_OK0;
			end
			S_Q_OUT: begin
				cmd.emit = st.out_free;
				cmd.sel = OS_QOK;
			end
			S_ALLOC_RD: cmd.alloc_rd = 1'b1;
			S_ALLOC_WR: begin
				cmd.emit = st.out_free;
				cmd.sel = OS_ALLOC;
				cmd.alloc_wr = st.out_free;
				cmd.loop_inc = st.out_free;
			end
			S_E_START: begin
				if (st.run_len_zero && st.run_err_zero && !st.epoch_max) cmd.epoch_inc = 1'b1;
			end
			S_WRAP: begin
				cmd.sweep_seen = 1'b1;
				cmd.epoch_one = st.sweep_last;
			end
			S_E_CHK: begin
				if (st.run_err_zero) begin
					if (st.run_full) cmd.err_long = 1'b1;
					else if (st.id_oob) cmd.err_bad = 1'b1;
					else cmd.elem_rd = 1'b1;
				end
			end
			S_E_MARK: begin
				if (st.elem_bad) cmd.err_bad = 1'b1;
				else cmd.elem_mark = 1'b1;
			end
			S_E_END: cmd.loop_clr = 1'b1;
			S_C_BUF: begin
				if (st.loop_done) cmd.loop_clr = 1'b1;
				else cmd.buf_rd = 1'b1;
			end
			S_C_CNT: cmd.cnt_rd_buf = 1'b1;
			S_C_CHK: begin
				if (st.cnt_max) cmd.err_ovf = 1'b1;
				else cmd.loop_inc = 1'b1;
			end
			S_A_BUF: if (!st.loop_done) cmd.buf_rd = 1'b1;
			S_A_CNT: cmd.cnt_rd_buf = 1'b1;
			S_A_UPD: begin
				cmd.apply = 1'b1;
				cmd.loop_inc = 1'b1;
			end
			S_RES: begin
				cmd.emit = st.out_free;
				cmd.sel = OS_RUN;
				cmd.run_clr = st.out_free;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/rcba_dp.sv
// ----------------------------------------------------------------------------
// rcba_dp: allocator datapath
// Count, free stack, mark and run memories, run bookkeeping, result register.
// ----------------------------------------------------------------------------
module rcba_dp #(
	parameter int NUM_BLOCKS  = rcba_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_RUN     = rcba_pkg::MAX_RUN_DEF,
	parameter int MAX_ALLOC   = rcba_pkg::MAX_ALLOC_DEF,
	parameter int COUNT_WIDTH = rcba_pkg::COUNT_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rcba_pkg::cmd_t  cmd,
	output rcba_pkg::stat_t st,
	input  logic [1:0]      kind,
	input  logic [15:0]     block_id,
	input  logic [6:0]      alloc_count,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [15:0]     block_id_res,
	output logic            id_valid,
	output logic [15:0]     ref_count,
	output logic            last_res
);
	import rcba_pkg::*;

	localparam int IDW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int TOPW = $clog2(NUM_BLOCKS + 1);
	localparam int RIW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int RUNW = $clog2(MAX_RUN + 1);
	localparam int LW   = (RUNW > 7) ? RUNW : 7;

	logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BLOCKS];
	logic [IDW-1:0]         stk_mem [NUM_BLOCKS];
	logic [EPOCH_W-1:0]     seen_mem [NUM_BLOCKS];
	logic [IDW-1:0]         buf_mem [MAX_RUN];

	kind_t                  kind_q;
	logic [15:0]            id_q;
	logic [6:0]             cnt_q;
	logic                   last_q;
	logic [TOPW-1:0]        top_q;
	logic [EPOCH_W-1:0]     epoch_q;
	logic [RUNW-1:0]        run_len_q;
	status_t                run_err_q;
	logic [LW-1:0]          loop_q;
	logic [IDW-1:0]         sweep_q;

	logic [COUNT_WIDTH-1:0] cnt_rd_q;
	logic [IDW-1:0]         stk_rd_q;
	logic [EPOCH_W-1:0]     seen_rd_q;
	logic [IDW-1:0]         buf_rd_q;

	logic                   cnt_re, cnt_we;
	logic [IDW-1:0]         cnt_ra, cnt_wa;
	logic [COUNT_WIDTH-1:0] cnt_wd, cnt_upd;
	logic                   stk_we;
	logic [IDW-1:0]         stk_wa, stk_wd, id_idx;
	logic                   seen_we;
	logic [IDW-1:0]         seen_wa;
	logic [EPOCH_W-1:0]     seen_wd;
	logic                   push;
	logic [COUNT_WIDTH+15:0] cnt_ext;

	assign id_idx = id_q[IDW-1:0];

	// count, stack and mark memory port muxing
	always_comb begin
		cnt_re = cmd.elem_rd | cmd.q_rd | cmd.cnt_rd_buf;
		cnt_ra = cmd.cnt_rd_buf ? buf_rd_q : id_idx;
		cnt_upd = (kind_q == K_RETAIN) ? cnt_rd_q + COUNT_WIDTH'(1) : cnt_rd_q - COUNT_WIDTH'(1);
		cnt_we = cmd.sweep_init | cmd.alloc_wr | cmd.apply;
		if (cmd.sweep_init) begin
			cnt_wa = sweep_q;
			cnt_wd = '0;
		end else if (cmd.alloc_wr) begin
			cnt_wa = stk_rd_q;
			cnt_wd = COUNT_WIDTH'(1);
		end else begin
			cnt_wa = buf_rd_q;
			cnt_wd = cnt_upd;
		end
		push = cmd.apply && (kind_q == K_RELEASE) && (cnt_upd == '0) &&
			(32'(top_q) < NUM_BLOCKS);
		stk_we = cmd.sweep_init | push;
		stk_wa = cmd.sweep_init ? sweep_q : top_q[IDW-1:0];
		stk_wd = cmd.sweep_init ? (IDW'(NUM_BLOCKS - 1) - sweep_q) : buf_rd_q;
		seen_we = cmd.sweep_init | cmd.sweep_seen | cmd.elem_mark;
		seen_wa = cmd.elem_mark ? id_idx : sweep_q;
		seen_wd = cmd.elem_mark ? epoch_q : '0;
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (cmd.alloc_rd) stk_rd_q <= stk_mem[IDW'(top_q - TOPW'(1))];
	end

	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		if (cmd.elem_rd) seen_rd_q <= seen_mem[id_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.elem_mark) buf_mem[run_len_q[RIW-1:0]] <= id_idx;
		if (cmd.buf_rd) buf_rd_q <= buf_mem[loop_q[RIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= kind_t'(kind);
			id_q   <= block_id;
			cnt_q  <= alloc_count;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= TOPW'(NUM_BLOCKS);
			epoch_q   <= '0;
			run_len_q <= '0;
			run_err_q <= ST_OK;
			loop_q    <= '0;
			sweep_q   <= '0;
		end else begin
			if (cmd.alloc_rd) top_q <= top_q - TOPW'(1);
			else if (push) top_q <= top_q + TOPW'(1);
			if (cmd.epoch_one) epoch_q <= EPOCH_W'(1);
			else if (cmd.epoch_inc) epoch_q <= epoch_q + EPOCH_W'(1);
			if (cmd.sweep_init || cmd.sweep_seen)
				sweep_q <= st.sweep_last ? '0 : sweep_q + IDW'(1);
			if (cmd.loop_clr) loop_q <= '0;
			else if (cmd.loop_inc) loop_q <= loop_q + LW'(1);
			if (cmd.run_clr) begin
				run_len_q <= '0;
				run_err_q <= ST_OK;
			end else begin
				if (cmd.elem_mark) run_len_q <= run_len_q + RUNW'(1);
				if (cmd.err_long) run_err_q <= ST_TOOLONG;
				else if (cmd.err_bad) run_err_q <= ST_BADID;
				else if (cmd.err_ovf) run_err_q <= ST_OVERFLOW;
			end
		end
	end

	always_comb begin
		st.kind         = kind_q;
		st.last         = last_q;
		st.sweep_last   = (sweep_q == IDW'(NUM_BLOCKS - 1));
		st.run_len_zero = (run_len_q == '0);
		st.run_err_zero = (run_err_q == ST_OK);
		st.run_full     = (32'(run_len_q) >= MAX_RUN);
		st.id_oob       = (32'(id_q) >= NUM_BLOCKS);
		st.elem_bad     = (cnt_rd_q == '0) || (seen_rd_q == epoch_q);
		st.epoch_max    = (epoch_q == '1);
		st.loop_done    = (loop_q == LW'(run_len_q));
		st.alloc_fail   = (32'(cnt_q) > MAX_ALLOC) || (32'(cnt_q) > 32'(top_q));
		st.alloc_zero   = (cnt_q == '0);
		st.alloc_last   = ((loop_q + LW'(1)) == LW'(cnt_q));
		st.cnt_max      = &cnt_rd_q;
		st.out_free     = !out_valid || out_ready;
	end

	assign cnt_ext = {16'b0, cnt_rd_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			block_id_res <= '0;
			id_valid     <= 1'b0;
			ref_count    <= '0;
			last_res     <= 1'b1;
			case (cmd.sel)
				OS_EMPTY: status <= ST_EMPTY;
				OS_OK0:   status <= ST_OK;
				OS_QBAD:  status <= ST_BADQUERY;
				OS_QOK: begin
					status    <= ST_OK;
					ref_count <= cnt_ext[15:0];
				end
				OS_ALLOC: begin
					status       <= ST_OK;
					block_id_res <= 16'(32'(stk_rd_q));
					id_valid     <= 1'b1;
					last_res     <= st.alloc_last;
				end
				default:  status <= run_err_q;
			endcase
		end
	end

endmodule

FILE: dv/tb_refcounted_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_refcounted_block_allocator: self-checking bench for the block allocator
// A directed table covers empty, zero-size and oversized allocates, bad and
// duplicate run ids, count queries and the pool refilling on release; a
// run that is too long and then random traffic follow. A shadow model of
// the pool predicts every result beat, and the beats are checked in order.
// ----------------------------------------------------------------------------
module tb_refcounted_block_allocator;
	import rcba_pkg::*;

	localparam int NB       = 1024;
	localparam int RUN_MAX  = 64;
	localparam int ALLOC_MX = 64;
	localparam int WDOG     = 200000;

	typedef struct packed {
		logic [2:0]  st;
		logic [15:0] id;
		logic        idv;
		logic [15:0] cnt;
		logic        lst;
	} beat_t;

	typedef struct {
		kind_t       k;
		logic [15:0] id;
		logic [6:0]  n;
		logic        lst;
		logic        chk;
		status_t     st;
	} row_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready;
	logic [1:0]  kind;
	logic [15:0] block_id;
	logic [6:0]  alloc_count;
	logic        last;
	logic        out_valid, out_ready;
	logic [2:0]  status;
	logic [15:0] block_id_res;
	logic        id_valid;
	logic [15:0] ref_count;
	logic        last_res;

	refcounted_block_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .block_id(block_id), .alloc_count(alloc_count), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_id_res(block_id_res), .id_valid(id_valid),
		.ref_count(ref_count), .last_res(last_res)
	);

	// shadow pool
	logic [15:0] counts[NB];
	logic [9:0]  stack_mem[NB];
	int          stack_top;
	logic [7:0]  marks[NB];
	logic [7:0]  epoch;
	logic [9:0]  run_ids[RUN_MAX];
	int          run_len;
	logic [2:0]  run_err;

	beat_t pending_beats[$];
	int    errors;
	int    idle_cycles;
	bit    stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got,
	                      input logic [31:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic pool_reset();
		for (int i = 0; i < NB; i++) begin
			counts[i] = '0;
			stack_mem[i] = 10'(NB - 1 - i);
			marks[i] = '0;
		end
		stack_top = NB;
		epoch = '0;
		run_len = 0;
		run_err = ST_OK;
	endtask

	function automatic beat_t mk(input logic [2:0] st, input logic [15:0] id,
	                             input logic v, input logic [15:0] c, input logic l);
		beat_t b;
		b.st = st; b.id = id; b.idv = v; b.cnt = c; b.lst = l;
		return b;
	endfunction

	task automatic queue_beat(input beat_t b);
		pending_beats = {pending_beats, b};
	endtask

	// predicts the beats of one item and queues them
	task automatic pool_step(input kind_t k, input logic [15:0] id,
	                         input logic [6:0] n, input logic lst);
		logic [2:0] st;
		logic [9:0] b;
		case (k)
			K_ALLOC: begin
				if (n > ALLOC_MX || n > stack_top)
					queue_beat(mk(ST_EMPTY, 16'd0, 1'b0, 16'd0, 1'b1));
				else if (n == 0)
					queue_beat(mk(ST_OK, 16'd0, 1'b0, 16'd0, 1'b1));
				else
					for (int i = 0; i < n; i++) begin
						stack_top--;
						b = stack_mem[stack_top];
						counts[b] = 16'd1;
						queue_beat(mk(ST_OK, 16'(b), 1'b1, 16'd0, i == n - 1));
					end
			end
			K_QUERY: begin
				if (id >= NB)
					queue_beat(mk(ST_BADQUERY, 16'd0, 1'b0, 16'd0, 1'b1));
				else
					queue_beat(mk(ST_OK, 16'd0, 1'b0, counts[id], 1'b1));
			end
			default: begin
				if (run_len == 0 && run_err == ST_OK) begin
					epoch++;
					if (epoch == 0) begin
						foreach (marks[i]) marks[i] = '0;
						epoch = 8'd1;
					end
				end
				if (run_err != ST_OK) ;
				else if (run_len >= RUN_MAX)
					run_err = ST_TOOLONG;
				else if (id >= NB || counts[id] == 0 || marks[id] == epoch)
					run_err = ST_BADID;
				else begin
					marks[id] = epoch;
					run_ids[run_len] = id[9:0];
					run_len++;
				end
				if (lst) begin
					st = run_err;
					if (st == ST_OK && k == K_RETAIN)
						for (int i = 0; i < run_len; i++)
							if (counts[run_ids[i]] == 16'hFFFF) st = ST_OVERFLOW;
					if (st == ST_OK)
						for (int i = 0; i < run_len; i++) begin
							b = run_ids[i];
							if (k == K_RETAIN) counts[b]++;
							else begin
								counts[b]--;
								if (counts[b] == 0 && stack_top < NB) begin
									stack_mem[stack_top] = b;
									stack_top++;
								end
							end
						end
					run_len = 0;
					run_err = ST_OK;
					queue_beat(mk(st, 16'd0, 1'b0, 16'd0, 1'b1));
				end
			end
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after the accept
	// with in_valid still high, so the next item may follow with no gap
	task automatic send(input kind_t k, input logic [15:0] id, input logic [6:0] n,
	                    input logic lst);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k; block_id <= id; alloc_count <= n; last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pool_step(k, id, n, lst);
		@(negedge clk);
	endtask

	function automatic logic [15:0] live_id();
		for (int t = 0; t < 8; t++) begin
			int i;
			i = $urandom_range(0, NB - 1);
			if (counts[i] != 0) return 16'(i);
		end
		return 16'($urandom_range(0, NB - 1));
	endfunction

	// directed table; chk rows carry a status that the model's prediction must match
	row_t rows[] = '{
		'{K_QUERY,   16'd0,     7'd0,   1'b0, 1'b1, ST_OK},
		'{K_QUERY,   16'hFFFF,  7'd0,   1'b0, 1'b1, ST_BADQUERY},
		'{K_ALLOC,   16'd0,     7'd0,   1'b0, 1'b1, ST_OK},
		'{K_ALLOC,   16'd0,     7'd127, 1'b0, 1'b1, ST_EMPTY},
		'{K_ALLOC,   16'd0,     7'd65,  1'b0, 1'b1, ST_EMPTY},
		'{K_ALLOC,   16'hFFFF,  7'd64,  1'b1, 1'b0, ST_OK},
		'{K_RETAIN,  16'd0,     7'd0,   1'b0, 1'b0, ST_OK},
		'{K_RETAIN,  16'd63,    7'd0,   1'b1, 1'b0, ST_OK},
		'{K_QUERY,   16'd63,    7'd0,   1'b0, 1'b0, ST_OK},
		'{K_RETAIN,  16'd5,     7'd0,   1'b0, 1'b0, ST_OK},
		'{K_RETAIN,  16'd5,     7'd0,   1'b1, 1'b1, ST_BADID},
		'{K_RELEASE, 16'd1023,  7'd0,   1'b1, 1'b1, ST_BADID},
		'{K_RELEASE, 16'hFFFF,  7'd0,   1'b1, 1'b1, ST_BADID},
		'{K_RELEASE, 16'd1,     7'd0,   1'b0, 1'b0, ST_OK},
		'{K_ALLOC,   16'd0,     7'd1,   1'b0, 1'b0, ST_OK},
		'{K_QUERY,   16'd1,     7'd0,   1'b0, 1'b0, ST_OK},
		'{K_RELEASE, 16'd2,     7'd0,   1'b1, 1'b0, ST_OK},
		'{K_RELEASE, 16'd1,     7'd0,   1'b1, 1'b0, ST_OK},
		'{K_QUERY,   16'd1,     7'd0,   1'b0, 1'b0, ST_OK},
		'{K_ALLOC,   16'd0,     7'd2,   1'b0, 1'b0, ST_OK}
	};

	initial begin
		int nrand;
		errors = 0; stim_done = 1'b0;
		in_valid = 1'b0; kind = K_ALLOC; block_id = '0; alloc_count = '0; last = 1'b0;
		arst_n = 1'b0;
		pool_reset();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		foreach (rows[r]) begin
			if (rows[r].chk) begin
				beat_t b;
				b = mk(rows[r].st, 16'd0, 1'b0, 16'd0, 1'b1);
				send(rows[r].k, rows[r].id, rows[r].n, rows[r].lst);
				if (pending_beats.size() == 0 || pending_beats[$] != b)
					report("directed row", 32'(r), 32'(rows[r].st));
			end else
				send(rows[r].k, rows[r].id, rows[r].n, rows[r].lst);
		end
		// a run past its length limit: 65 live ids
		for (int i = 0; i < 65; i++)
			send(K_RETAIN, 16'(i < 64 ? i : 64), 7'd0, i == 64);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_beats.size() != 0) @(negedge clk);
		nrand = 0;
		while (nrand < 20) begin
			int sel, len;
			sel = $urandom_range(0, 9);
			if (sel < 2) begin
				send(K_ALLOC, 16'($urandom), 7'($urandom_range(0, 3) == 0 ?
				     $urandom : $urandom_range(0, 8)), 1'($urandom));
				nrand++;
			end else if (sel < 4) begin
				send(K_QUERY, $urandom_range(0, 1) ? live_id() : 16'($urandom),
				     7'($urandom), 1'($urandom));
				nrand++;
			end else begin
				kind_t rk;
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					logic [15:0] id;
					rk = $urandom_range(0, 2) == 0 ? K_RELEASE : K_RETAIN;
					id = $urandom_range(0, 9) == 0 ? 16'($urandom) : live_id();
					send(rk, id, 7'($urandom), i == len - 1);
					nrand++;
				end
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// result side
	initial begin
		beat_t got, want;
		int stall;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = mk(status, block_id_res, id_valid, ref_count, last_res);
			if (pending_beats.size() == 0) begin
				report("unexpected beat", 32'(got.st), 32'd0);
			end else begin
				want = pending_beats.pop_front();
				if (got.st  != want.st)  report("status", 32'(got.st), 32'(want.st));
				if (got.id  != want.id)  report("block_id_res", 32'(got.id), 32'(want.id));
				if (got.idv != want.idv) report("id_valid", 32'(got.idv), 32'(want.idv));
				if (got.cnt != want.cnt) report("ref_count", 32'(got.cnt), 32'(want.cnt));
				if (got.lst != want.lst) report("last_res", 32'(got.lst), 32'(want.lst));
			end
			@(negedge clk);
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WDOG) begin
				$display("FAIL");
				$finish;
			end
			if (stim_done && pending_beats.size() == 0) begin
				repeat (500) @(posedge clk);
				if (errors == 0 && pending_beats.size() == 0) $display("PASS");
				else $display("FAIL");
				$finish;
			end
		end
	end

endmodule

FILE: refcounted_block_allocator.f
rtl/rcba_pkg.sv
rtl/rcba_ctrl.sv
rtl/rcba_dp.sv
rtl/refcounted_block_allocator.sv
dv/tb_refcounted_block_allocator.sv
